FILE: rtl/mi4_pkg.sv
// Package: widths, command/status types and operand tables for the 4x4 inverse.
package mi4_pkg;

    localparam int POS_W  = 4;
    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int TRIP_W = 48;
    localparam int COF_W  = 49;
    localparam int DET_W  = 67;
    localparam int DMAG_W = 66;
    localparam int QB     = 16;
    localparam int N_ELEM = 16;

    localparam logic [POS_W-1:0] POS_LAST = 4'd15;

    // sequencer limits
    localparam logic [2:0] TERM_LAST    = 3'd5;
    localparam logic [4:0] COF_PH_LAST  = 5'd4;
    localparam logic [4:0] DET_PH_LAST  = 5'd3;
    localparam logic [4:0] DIV_PH_INIT  = 5'd1;
    localparam logic [4:0] DIV_PH_LAST  = 5'd18;
    localparam logic [4:0] SING_PH_LAST = 5'd1;
    localparam logic [1:0] DET_K_LAST   = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_LOAD = 3'd1,
        OP_COF  = 3'd2,
        OP_DET  = 3'd3,
        OP_CHK  = 3'd4,
        OP_DIV  = 3'd5,
        OP_SING = 3'd6,
        OP_PUT  = 3'd7
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] k;
        logic [2:0] t;
        logic [4:0] ph;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
        logic det_zero;
        logic singular;
    } t_stat;

    // 3x3 minor elements (row-major 0..8) of each expansion term
    localparam logic [3:0] TERM_E [6][3] = '{
        '{4'd0, 4'd4, 4'd8}, '{4'd0, 4'd5, 4'd7}, '{4'd1, 4'd3, 4'd8},
        '{4'd1, 4'd5, 4'd6}, '{4'd2, 4'd3, 4'd7}, '{4'd2, 4'd4, 4'd6}
    };
    localparam logic [5:0] TERM_NEG = 6'b100110;

    localparam logic [1:0] E_ROW [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] E_COL [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

    function automatic logic [1:0] f_skip(input logic [1:0] n, input logic [1:0] x);
        return (x < n) ? x : x + 2'd1;
    endfunction

    // cofactor k = i*4+j uses the minor without row j and column i
    function automatic logic [3:0] f_elem_addr(input logic [3:0] k, input logic [3:0] e);
        logic [1:0] row;
        logic [1:0] col;
        row = f_skip(k[1:0], E_ROW[e]);
        col = f_skip(k[3:2], E_COL[e]);
        return {row, col};
    endfunction

endpackage

FILE: rtl/mi4_ifs.sv
// Interfaces: element request channel and result channel.
interface mi4_in_if;
    import mi4_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [POS_W-1:0]         position;
    logic signed [ELEM_W-1:0] value;
    modport source(output valid, position, value, input ready);
    modport sink(input valid, position, value, output ready);
endinterface

interface mi4_out_if;
    import mi4_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [POS_W-1:0]         out_position;
    logic signed [ELEM_W-1:0] out_value;
    logic                     singular;
    logic                     last;
    modport source(output valid, out_position, out_value, singular, last, input ready);
    modport sink(input valid, out_position, out_value, singular, last, output ready);
endinterface

FILE: rtl/matrix_inverse_4x4_core.sv
// Top level: 4x4 signed Q8.8 matrix inverse by cofactors.
// Elements are loaded one request per cycle, each written at its row-major
// position; a request at position 15 also starts the inversion, and no further
// request is taken until all sixteen results have been handed to the output
// register. Inversion time after position 15 is set by the multipliers and the
// one-bit-per-cycle divider: the sixteen cofactors (six triple products each),
// the determinant, the singular check, then each result in turn (16 quotient
// steps); a singular matrix skips the division for each result. Results come
// out in position order with last on the sixteenth; on a nonzero determinant
// the inverse replaces the stored matrix. The element store reads as zero
// after reset.
module matrix_inverse_4x4_core #(
    parameter int ELEMENT_FRAC_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mi4_in_if.sink     i_in,
    mi4_out_if.source  o_out
);
    import mi4_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    mi4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_pos   (i_in.position),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mi4_dp #(
        .FRAC (ELEMENT_FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_pos   (i_in.position),
        .i_val   (i_in.value),
        .o_stat  (w_stat),
        .o_out   (o_out)
    );

endmodule

FILE: rtl/mi4_ctrl.sv
// Sequencer for load, cofactor, determinant, division and result phases.
module mi4_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [3:0]            i_in_pos,
    output logic                  o_in_ready,
    input  mi4_pkg::t_stat        i_stat,
    output mi4_pkg::t_cmd         o_cmd
);
    import mi4_pkg::*;

    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_COF  = 7'b0000010,
        S_DET  = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_SING = 7'b0100000,
        S_PUT  = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_k, n_k;
    logic [2:0] r_t, n_t;
    logic [4:0] r_ph, n_ph;
    logic       w_acc;

    assign o_in_ready = (r_state == S_LOAD);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_t     = r_t;
        n_ph    = r_ph;
        o_cmd.k  = r_k;
        o_cmd.t  = r_t;
        o_cmd.ph = r_ph;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_LOAD: begin
                if (w_acc) begin
                    o_cmd.op = OP_LOAD;
                    if (i_in_pos == POS_LAST) begin
                        n_state = S_COF;
                        n_k     = '0;
                        n_t     = '0;
                        n_ph    = '0;
                    end
                end
            end
            S_COF: begin
                o_cmd.op = OP_COF;
                if (r_ph == COF_PH_LAST) begin
                    n_ph = '0;
                    if (r_t == TERM_LAST) begin
                        n_t = '0;
                        n_k = r_k + 4'd1;
                        if (r_k == POS_LAST) n_state = S_DET;
                    end else begin
                        n_t = r_t + 3'd1;
                    end
                end else begin
                    n_ph = r_ph + 5'd1;
                end
            end
            S_DET: begin
                o_cmd.op = OP_DET;
                if (r_ph == DET_PH_LAST) begin
                    n_ph = '0;
                    n_k  = r_k + 4'd1;
                    if (r_k[1:0] == DET_K_LAST) begin
                        n_k     = '0;
                        n_state = S_CHK;
                    end
                end else begin
                    n_ph = r_ph + 5'd1;
                end
            end
            S_CHK: begin
                o_cmd.op = OP_CHK;
                n_ph     = '0;
                n_k      = '0;
                n_state  = i_stat.det_zero ? S_SING : S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (r_ph == DIV_PH_LAST) begin
                    n_ph    = '0;
                    n_state = S_PUT;
                end else begin
                    n_ph = r_ph + 5'd1;
                end
            end
            S_SING: begin
                o_cmd.op = OP_SING;
                if (r_ph == SING_PH_LAST) begin
                    n_ph    = '0;
                    n_state = S_PUT;
                end else begin
                    n_ph = r_ph + 5'd1;
                end
            end
            S_PUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_PUT;
                    n_k      = r_k + 4'd1;
                    if (r_k == POS_LAST) n_state = S_LOAD;
                    else n_state = i_stat.singular ? S_SING : S_DIV;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_k     <= '0;
            r_t     <= '0;
            r_ph    <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_t     <= n_t;
            r_ph    <= n_ph;
        end
    end

`ifndef ASSERT_OFF
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_pos == POS_LAST) |=> (r_state == S_COF && r_k == 4'd0))
        else $error("inversion did not start on last element");
    a_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |=> ((r_state == S_SING) == $past(i_stat.det_zero)))
        else $error("singular path mismatch");
    a_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && i_stat.out_busy) |=> (r_state == S_PUT && $stable(r_k)))
        else $error("result dropped while output busy");
`endif

endmodule

FILE: rtl/mi4_dp.sv
// Datapath: element and cofactor stores, multipliers, divider, output register.
module mi4_dp #(
    parameter int FRAC = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mi4_pkg::t_cmd                 i_cmd,
    input  logic [mi4_pkg::POS_W-1:0]     i_pos,
    input  logic signed [mi4_pkg::ELEM_W-1:0] i_val,
    output mi4_pkg::t_stat                o_stat,
    mi4_out_if.source                     o_out
);
    import mi4_pkg::*;

    localparam int SH    = 2 * FRAC;
    localparam int NUMW  = TRIP_W + SH;
    localparam int REMIW = NUMW - QB;

    logic signed [ELEM_W-1:0] r_mat [N_ELEM];
    logic [N_ELEM-1:0]        r_mat_vld;
    logic signed [COF_W-1:0]  r_cof_mem [N_ELEM];

    logic signed [ELEM_W-1:0] r_rd;
    logic signed [COF_W-1:0]  r_cof;
    logic signed [ELEM_W-1:0] r_opa;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [TRIP_W-1:0] r_p2;
    logic signed [COF_W-1:0]  r_acc;
    logic signed [48:0]       r_pa;
    logic signed [32:0]       r_pb;
    logic signed [DET_W-1:0]  r_det;
    logic                     r_sing, r_dneg, r_cneg, r_sat;
    logic [DMAG_W-1:0]        r_dmag;
    logic [DMAG_W-1:0]        r_rem;
    logic [QB-1:0]            r_nlo;
    logic [QB-1:0]            r_q;
    logic signed [ELEM_W-1:0] r_res;

    logic                     r_ov;
    logic [POS_W-1:0]         r_opos;
    logic signed [ELEM_W-1:0] r_oval;
    logic                     r_osing, r_olast;

    logic [3:0]               w_maddr, w_caddr;
    logic signed [COF_W-1:0]  w_acc_n, w_cof_w;
    logic signed [DET_W-1:0]  w_det_neg;
    logic [TRIP_W-1:0]        w_cmag;
    logic [NUMW-1:0]          w_num;
    logic [DMAG_W:0]          w_rem2, w_diff;
    logic                     w_ge;
    logic signed [ELEM_W-1:0] w_res;
    logic                     w_put, w_mwr;
    logic [3:0]               w_mwa;
    logic signed [ELEM_W-1:0] w_mwd;

    always_comb begin
        case (i_cmd.op)
            OP_COF:  w_maddr = f_elem_addr(i_cmd.k, TERM_E[i_cmd.t][i_cmd.ph[1:0]]);
            OP_DET:  w_maddr = {2'b00, i_cmd.k[1:0]};
            default: w_maddr = i_cmd.k;
        endcase
        w_caddr = (i_cmd.op == OP_DET) ? {i_cmd.k[1:0], 2'b00} : i_cmd.k;
    end

    // triple product accumulation and cofactor sign
    always_comb begin
        logic signed [COF_W-1:0] base;
        logic signed [COF_W-1:0] term;
        base    = (i_cmd.t == 3'd0) ? '0 : r_acc;
        term    = {r_p2[TRIP_W-1], r_p2};
        w_acc_n = TERM_NEG[i_cmd.t] ? base - term : base + term;
        w_cof_w = (i_cmd.k[2] ^ i_cmd.k[0]) ? -w_acc_n : w_acc_n;
    end

    assign w_det_neg = -r_det;
    assign w_cmag    = r_cof[COF_W-1] ? TRIP_W'(-r_cof) : r_cof[TRIP_W-1:0];
    assign w_num     = {w_cmag, {SH{1'b0}}};
    assign w_rem2    = {r_rem, r_nlo[QB-1]};
    assign w_diff    = w_rem2 - {1'b0, r_dmag};
    assign w_ge      = (w_rem2 >= {1'b0, r_dmag});

    always_comb begin
        if (r_sat) begin
            w_res = (r_cneg != r_dneg) ? 16'sh8000 : 16'sh7FFF;
        end else if (r_cneg != r_dneg) begin
            w_res = (r_q > 16'h8000) ? 16'sh8000 : -$signed(r_q);
        end else begin
            w_res = (r_q > 16'h7FFF) ? 16'sh7FFF : $signed(r_q);
        end
    end

    assign w_put = (i_cmd.op == OP_PUT);
    assign w_mwr = (i_cmd.op == OP_LOAD) || (w_put && !r_sing);
    assign w_mwa = w_put ? i_cmd.k : i_pos;
    assign w_mwd = w_put ? r_res : i_val;

    // matrix store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_mwr) r_mat[w_mwa] <= w_mwd;
        r_rd <= r_mat_vld[w_maddr] ? r_mat[w_maddr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mat_vld <= '0;
        else if (w_mwr) r_mat_vld[w_mwa] <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_COF && i_cmd.t == TERM_LAST && i_cmd.ph == COF_PH_LAST)
            r_cof_mem[i_cmd.k] <= w_cof_w;
        r_cof <= r_cof_mem[w_caddr];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_COF: begin
                case (i_cmd.ph)
                    5'd1: r_opa <= r_rd;
                    5'd2: r_p1  <= r_opa * r_rd;
                    5'd3: r_p2  <= r_p1 * r_rd;
                    5'd4: r_acc <= w_acc_n;
                    default: ;
                endcase
            end
            OP_DET: begin
                case (i_cmd.ph)
                    5'd0: if (i_cmd.k[1:0] == 2'd0) r_det <= '0;
                    5'd1: r_pa <= r_rd * $signed({1'b0, r_cof[31:0]});
                    5'd2: r_pb <= r_rd * $signed(r_cof[COF_W-1:32]);
                    5'd3: r_det <= r_det + ({{(DET_W-33){r_pb[32]}}, r_pb} <<< 32)
                                   + {{(DET_W-49){r_pa[48]}}, r_pa};
                    default: ;
                endcase
            end
            OP_CHK: begin
                r_sing <= (r_det == '0);
                r_dneg <= r_det[DET_W-1];
                r_dmag <= r_det[DET_W-1] ? w_det_neg[DMAG_W-1:0] : r_det[DMAG_W-1:0];
            end
            OP_DIV: begin
                if (i_cmd.ph == DIV_PH_INIT) begin
                    r_cneg <= r_cof[COF_W-1];
                    r_sat  <= ({{(DMAG_W-REMIW){1'b0}}, w_num[NUMW-1:QB]} >= r_dmag);
                    r_rem  <= {{(DMAG_W-REMIW){1'b0}}, w_num[NUMW-1:QB]};
                    r_nlo  <= w_num[QB-1:0];
                    r_q    <= '0;
                end else if (i_cmd.ph == DIV_PH_LAST) begin
                    r_res <= w_res;
                end else if (i_cmd.ph > DIV_PH_INIT) begin
                    r_rem <= w_ge ? w_diff[DMAG_W-1:0] : w_rem2[DMAG_W-1:0];
                    r_q   <= {r_q[QB-2:0], w_ge};
                    r_nlo <= {r_nlo[QB-2:0], 1'b0};
                end
            end
            OP_SING: begin
                if (i_cmd.ph == SING_PH_LAST) r_res <= r_rd;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_put) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_opos  <= i_cmd.k;
            r_oval  <= r_res;
            r_osing <= r_sing;
            r_olast <= (i_cmd.k == POS_LAST);
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.out_position = r_opos;
    assign o_out.out_value    = r_oval;
    assign o_out.singular     = r_osing;
    assign o_out.last         = r_olast;

    assign o_stat.out_busy = r_ov && !o_out.ready;
    assign o_stat.det_zero = (r_det == '0);
    assign o_stat.singular = r_sing;

endmodule

FILE: tb/sv/tb_matrix_inverse_4x4_core.sv
// Testbench for the 4x4 cofactor matrix inverse: random and directed loads, scoreboard check.
module tb_matrix_inverse_4x4_core;
    import mi4_pkg::*;

    typedef struct {
        logic [POS_W-1:0]         pos;
        logic signed [ELEM_W-1:0] val;
        logic                     sing;
        logic                     last;
    } t_result;

    // Predicts inverse runs from a private copy of the element store.
    class inverse_scoreboard;
        logic signed [ELEM_W-1:0] elems [16];
        t_result pending [$];
        int errors;
        int runs;
        int singular_runs;

        function new();
            foreach (elems[i]) elems[i] = '0;
            errors = 0;
            runs = 0;
            singular_runs = 0;
        endfunction

        function longint minor3(int rr, int cc);
            longint m [9];
            int k;
            k = 0;
            for (int r = 0; r < 4; r++) begin
                if (r == rr) continue;
                for (int c = 0; c < 4; c++) begin
                    if (c == cc) continue;
                    m[k] = longint'(elems[r * 4 + c]);
                    k++;
                end
            end
            return m[0] * (m[4] * m[8] - m[5] * m[7])
                 - m[1] * (m[3] * m[8] - m[5] * m[6])
                 + m[2] * (m[3] * m[7] - m[4] * m[6]);
        endfunction

        function void note_request(logic [POS_W-1:0] pos, logic signed [ELEM_W-1:0] val);
            longint cof [16];
            logic signed [127:0] det;
            logic [127:0] dmag;
            logic [127:0] num;
            logic [127:0] q;
            logic signed [ELEM_W-1:0] res [16];
            bit sing;
            bit dneg;
            bit cneg;
            t_result r;
            elems[pos] = val;
            if (pos != POS_LAST) return;
            runs++;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    cof[i * 4 + j] = ((i + j) % 2) ? -minor3(j, i) : minor3(j, i);
            det = 0;
            for (int j = 0; j < 4; j++)
                det += 128'(signed'(longint'(elems[j]) * cof[j * 4]));
            sing = (det == 0);
            dneg = det[127];
            dmag = dneg ? -det : det;
            for (int k = 0; k < 16; k++) begin
                if (sing) begin
                    res[k] = elems[k];
                end else begin
                    cneg = cof[k] < 0;
                    num = 128'(cneg ? -cof[k] : cof[k]) << (2 * 8);
                    q = num / dmag;
                    if (cneg != dneg) res[k] = (q > 32768) ? -16'sd32768 : -$signed(q[16:0]);
                    else res[k] = (q > 32767) ? 16'sd32767 : q[15:0];
                end
                r.pos = POS_W'(k);
                r.val = res[k];
                r.sing = sing;
                r.last = (k == 15);
                pending.push_back(r);
            end
            if (sing) singular_runs++;
            else foreach (elems[k]) elems[k] = res[k];
        endfunction

        function bit check_result(t_result got, output string msg);
            t_result exp_r;
            if (pending.size() == 0) begin
                msg = $sformatf("unexpected result pos=%0d val=%0d", got.pos, got.val);
                return 0;
            end
            exp_r = pending.pop_front();
            if (got.pos !== exp_r.pos || got.val !== exp_r.val
                    || got.sing !== exp_r.sing || got.last !== exp_r.last) begin
                msg = $sformatf("pos %0d/%0d val %0d/%0d sing %0b/%0b last %0b/%0b (got/exp)",
                    got.pos, exp_r.pos, got.val, exp_r.val, got.sing, exp_r.sing,
                    got.last, exp_r.last);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    mi4_in_if  in_ch();
    mi4_out_if out_ch();

    matrix_inverse_4x4_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    inverse_scoreboard sb;
    int mismatches;
    longint cycles;
    bit hold_req;

    initial i_clk = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report(string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [ELEM_W-1:0] rand_elem();
        int p;
        p = $urandom_range(0, 9);
        if (p < 5) return ELEM_W'($signed($urandom_range(0, 1023)) - 512);
        if (p < 7) return ELEM_W'($urandom);
        if (p < 8) return 16'sh0100;
        if (p < 9) return 16'sh8000;
        return 16'sh7fff;
    endfunction

    // valid stays high across back-to-back requests; dropped only for a gap
    task automatic send_request(logic [POS_W-1:0] pos, logic [ELEM_W-1:0] val);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.position <= pos;
        in_ch.value    <= val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_request(pos, val);
    endtask

    // kind 0 identity-ish, 1 random, 2 singular (duplicate rows), 3 scaled tiny
    task automatic send_matrix(int kind);
        logic [ELEM_W-1:0] m [16];
        foreach (m[i]) m[i] = rand_elem();
        if (kind == 0) foreach (m[i]) m[i] = (i % 5 == 0) ? 16'sh0100 : 16'sh0000;
        if (kind == 2) for (int c = 0; c < 4; c++) m[4 + c] = m[c];
        if (kind == 3) foreach (m[i]) m[i] = (i % 5 == 0) ? 16'sh0001 : 16'sh0000;
        for (int i = 0; i < 16; i++) send_request(POS_W'(i), m[i]);
    endtask

    initial begin
        string msg;
        t_result got;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got.pos  = out_ch.out_position;
                got.val  = out_ch.out_value;
                got.sing = out_ch.singular;
                got.last = out_ch.last;
                if (!sb.check_result(got, msg)) report(msg);
            end
        end
    end

    initial begin
        int g;
        bit held;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (2000) @(posedge i_clk);
            end else begin
                g = gap_len();
                if (g == 0) begin
                    out_ch.ready <= 1'b1;
                end else begin
                    out_ch.ready <= 1'b0;
                    repeat (g - 1) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 3000000) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        mismatches = 0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.position = '0;
        in_ch.value = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // all-zero store: singular straight from reset
        send_request(POS_LAST, 16'sh0000);
        send_matrix(0);
        send_request(POS_LAST, 16'sh7fff);
        send_matrix(3);
        // long output stall while inputs keep coming
        hold_req = 1'b1;
        send_matrix(2);
        for (int n = 0; n < 17; n++) begin
            if ($urandom_range(0, 9) < 8) send_matrix($urandom_range(0, 9) < 7 ? 1 : 2);
            else send_request(POS_W'($urandom_range(0, 15)), rand_elem());
        end
        send_request(POS_LAST, 16'sh8000);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (900) @(posedge i_clk);
        $display("covered %0d inversions, %0d of them singular", sb.runs, sb.singular_runs);
        if (mismatches == 0 && sb.pending.size() == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
